/* design/sai_pkg.sv */
package sai_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NW          = COORD_WIDTH + 1;
    localparam int QW          = NW + FRAC_BITS;
    localparam int TW          = QW + 1;

    localparam logic signed [TW-1:0] T_SAT = {1'b0, {QW{1'b1}}};
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [NW-1:0]          mag_t;
    typedef logic [QW-1:0]          quot_t;
    typedef logic signed [TW-1:0]   param_t;

    typedef struct packed {
        logic neg_lo_x;
        logic neg_hi_x;
        logic neg_lo_y;
        logic neg_hi_y;
        logic par_x;
        logic par_y;
        logic pok_x;
        logic pok_y;
        logic ep_in;
    } side_t;

    function automatic mag_t abs_mag(input logic signed [NW-1:0] v);
        logic signed [NW-1:0] neg_v;
        neg_v = -v;
        return v[NW-1] ? mag_t'(neg_v) : mag_t'(v);
    endfunction

    function automatic param_t apply_sign(input quot_t q, input logic neg);
        param_t p;
        p = param_t'({1'b0, q});
        return neg ? -p : p;
    endfunction

endpackage

/* design/sai_div.sv */
module sai_div
    import sai_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  mag_t  num,
    input  mag_t  den,
    output quot_t quo
);

    mag_t  r_reg   [QW];
    quot_t dvd_reg [QW];
    quot_t q_reg   [QW];
    mag_t  m_reg   [QW];

    mag_t  r_in   [QW];
    quot_t dvd_in [QW];
    quot_t q_in   [QW];
    mag_t  m_in   [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_stage
            logic [NW:0] shifted;
            logic [NW:0] diff;
            logic        ge;

            if (i == 0) begin : g_first
                assign r_in[i]   = '0;
                assign dvd_in[i] = {num, {FRAC_BITS{1'b0}}};
                assign q_in[i]   = '0;
                assign m_in[i]   = den;
            end else begin : g_next
                assign r_in[i]   = r_reg[i-1];
                assign dvd_in[i] = dvd_reg[i-1];
                assign q_in[i]   = q_reg[i-1];
                assign m_in[i]   = m_reg[i-1];
            end

            assign shifted = {r_in[i], dvd_in[i][QW-1]};
            assign diff    = shifted - {1'b0, m_in[i]};
            assign ge      = shifted >= {1'b0, m_in[i]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i]   <= ge ? diff[NW-1:0] : shifted[NW-1:0];
                    dvd_reg[i] <= {dvd_in[i][QW-2:0], 1'b0};
                    q_reg[i]   <= {q_in[i][QW-2:0], ge};
                    m_reg[i]   <= m_in[i];
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW-1];

endmodule

/* design/segment_aabb_intersect.sv */
// Channel   Direction  Fields
// s_        in         start_x/y, end_x/y, box_min_x/y, box_max_x/y
// m_        out        hit, endpoint_inside
//
// One item per cycle while m_ does not stall. An item passes the input registers,
// the four restoring dividers (one quotient bit per stage), c1_reg and the output.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
// A stall on m_ holds the whole pipeline; s_ready drops only while a result waits.
module segment_aabb_intersect
    import sai_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_start_x,
    input  coord_t s_start_y,
    input  coord_t s_end_x,
    input  coord_t s_end_y,
    input  coord_t s_box_min_x,
    input  coord_t s_box_min_y,
    input  coord_t s_box_max_x,
    input  coord_t s_box_max_y,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_hit,
    output logic   m_endpoint_inside
);

    typedef struct packed {
        param_t en_x;
        param_t ex_x;
        param_t en_y;
        param_t ex_y;
        side_t  side;
    } comb_t;

    logic en;

    logic  valid_reg [QW+1];
    side_t side_reg  [QW+1];
    mag_t  nlx_reg, nhx_reg, nly_reg, nhy_reg, dx_reg, dy_reg;

    logic signed [NW-1:0] dx, dy, nlx, nhx, nly, nhy;
    logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey, x0, y0, x1, y1;
    side_t side_next;

    quot_t qlx, qhx, qly, qhy;

    logic  c1_valid_reg;
    comb_t c1_reg;
    comb_t c1_next;
    param_t alx, ahx, aly, ahy;

    logic   m_valid_reg, m_hit_reg, m_inside_reg;
    logic   hit_next;
    param_t lo, hi, t;
    logic   ok, miss;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign sx = s_start_x;
    assign sy = s_start_y;
    assign ex = s_end_x;
    assign ey = s_end_y;
    assign x0 = s_box_min_x;
    assign y0 = s_box_min_y;
    assign x1 = s_box_max_x;
    assign y1 = s_box_max_y;

    always_comb begin
        dx  = NW'(ex) - NW'(sx);
        dy  = NW'(ey) - NW'(sy);
        nlx = NW'(x0) - NW'(sx);
        nhx = NW'(x1) - NW'(sx);
        nly = NW'(y0) - NW'(sy);
        nhy = NW'(y1) - NW'(sy);
        side_next.neg_lo_x = nlx[NW-1] ^ dx[NW-1];
        side_next.neg_hi_x = nhx[NW-1] ^ dx[NW-1];
        side_next.neg_lo_y = nly[NW-1] ^ dy[NW-1];
        side_next.neg_hi_y = nhy[NW-1] ^ dy[NW-1];
        side_next.par_x    = dx == '0;
        side_next.par_y    = dy == '0;
        side_next.pok_x    = (sx > x0) && (sx < x1);
        side_next.pok_y    = (sy > y0) && (sy < y1);
        side_next.ep_in    = ((sx > x0) && (sx < x1) && (sy > y0) && (sy < y1)) ||
                             ((ex > x0) && (ex < x1) && (ey > y0) && (ey < y1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k <= QW; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= QW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            nlx_reg <= abs_mag(nlx);
            nhx_reg <= abs_mag(nhx);
            nly_reg <= abs_mag(nly);
            nhy_reg <= abs_mag(nhy);
            dx_reg  <= abs_mag(dx);
            dy_reg  <= abs_mag(dy);
        end
    end

    sai_div u_div_lx (.aclk(aclk), .en(en), .num(nlx_reg), .den(dx_reg), .quo(qlx));
    sai_div u_div_hx (.aclk(aclk), .en(en), .num(nhx_reg), .den(dx_reg), .quo(qhx));
    sai_div u_div_ly (.aclk(aclk), .en(en), .num(nly_reg), .den(dy_reg), .quo(qly));
    sai_div u_div_hy (.aclk(aclk), .en(en), .num(nhy_reg), .den(dy_reg), .quo(qhy));

    always_comb begin
        alx = apply_sign(qlx, side_reg[QW].neg_lo_x);
        ahx = apply_sign(qhx, side_reg[QW].neg_hi_x);
        aly = apply_sign(qly, side_reg[QW].neg_lo_y);
        ahy = apply_sign(qhy, side_reg[QW].neg_hi_y);
        c1_next.en_x = (alx < ahx) ? alx : ahx;
        c1_next.ex_x = (alx < ahx) ? ahx : alx;
        c1_next.en_y = (aly < ahy) ? aly : ahy;
        c1_next.ex_y = (aly < ahy) ? ahy : aly;
        c1_next.side = side_reg[QW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
        end else if (en) begin
            c1_valid_reg <= valid_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg <= c1_next;
        end
    end

    always_comb begin
        lo = -T_SAT;
        hi = T_SAT;
        if (!c1_reg.side.par_x) begin
            lo = c1_reg.en_x;
            hi = c1_reg.ex_x;
        end
        if (!c1_reg.side.par_y) begin
            if (c1_reg.en_y > lo) lo = c1_reg.en_y;
            if (c1_reg.ex_y < hi) hi = c1_reg.ex_y;
        end
        ok   = (!c1_reg.side.par_x || c1_reg.side.pok_x) &&
               (!c1_reg.side.par_y || c1_reg.side.pok_y);
        miss = (hi < 0) || (lo > hi);
        t    = (lo < 0) ? hi : lo;
        hit_next = c1_reg.side.ep_in || (ok && !miss && (t > 0) && (t < T_ONE));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg  <= c1_valid_reg;
            m_hit_reg    <= hit_next;
            m_inside_reg <= c1_reg.side.ep_in;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_endpoint_inside = m_inside_reg;

endmodule

/* design/sai_checker.sv */
module sai_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit,
    input logic m_endpoint_inside
);

    a_inside_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_endpoint_inside |-> m_hit)
        else $error("endpoint inside without hit");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with no result waiting");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_endpoint_inside))
        else $error("stalled result changed");

endmodule

bind segment_aabb_intersect sai_checker u_sai_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_hit             (m_hit),
    .m_endpoint_inside (m_endpoint_inside)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import sai_pkg::*;

    localparam int N_RAND    = 2000;
    localparam int LATENCY   = 52;
    localparam int MAX_CYC   = 400000;
    localparam int HOLD_CYC  = 300;
    localparam longint ONE   = 64'sd1 << FRAC_BITS;
    localparam longint PSAT  = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        coord_t sx, sy, ex, ey, x0, y0, x1, y1;
        bit     fixed;
        bit     hit;
        bit     ins;
    } query_t;

    typedef struct {
        bit hit;
        bit ins;
    } verdict_t;

    logic   aclk = 0;
    logic   aresetn = 0;
    logic   s_valid = 0;
    logic   s_ready;
    coord_t s_start_x = '0, s_start_y = '0, s_end_x = '0, s_end_y = '0;
    coord_t s_box_min_x = '0, s_box_min_y = '0, s_box_max_x = '0, s_box_max_y = '0;
    logic   m_valid;
    logic   m_ready = 0;
    logic   m_hit;
    logic   m_endpoint_inside;

    bit     cur_fixed = 0, cur_hit = 0, cur_ins = 0;
    verdict_t verdicts[$];
    query_t   rows[$];
    int     errors = 0;
    int     accepted = 0;
    int     total_items = 0;
    int     cycles = 0;

    segment_aabb_intersect dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint to_fix(coord_t v);
        return longint'($signed(v));
    endfunction

    function automatic longint slab_param(longint num, longint den);
        bit neg;
        longint unsigned n, m, qi, r, frac, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        m = (den < 0) ? -den : den;
        qi = n / m;
        r = n % m;
        frac = 0;
        if (qi > (PSAT >> FRAC_BITS)) begin
            q = PSAT;
        end else begin
            for (int i = 0; i < FRAC_BITS; i++) begin
                r = r << 1;
                frac = frac << 1;
                if (r >= m) begin
                    r = r - m;
                    frac = frac | 1;
                end
            end
            q = (qi << FRAC_BITS) | frac;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit narrow_axis(longint s, longint e, longint bmin, longint bmax,
                                       inout longint lo, inout longint hi);
        longint d, a, b;
        d = e - s;
        if (d == 0) return (s > bmin) && (s < bmax);
        a = slab_param(bmin - s, d);
        b = slab_param(bmax - s, d);
        if (((a < b) ? a : b) > lo) lo = (a < b) ? a : b;
        if (((a < b) ? b : a) < hi) hi = (a < b) ? b : a;
        return 1;
    endfunction

    function automatic verdict_t classify(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                          coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        verdict_t v;
        longint psx, psy, pex, pey, bx0, by0, bx1, by1, lo, hi, t;
        bit ok;
        psx = to_fix(sx); psy = to_fix(sy); pex = to_fix(ex); pey = to_fix(ey);
        bx0 = to_fix(x0); by0 = to_fix(y0); bx1 = to_fix(x1); by1 = to_fix(y1);
        v.ins = (psx > bx0 && psx < bx1 && psy > by0 && psy < by1) ||
                (pex > bx0 && pex < bx1 && pey > by0 && pey < by1);
        v.hit = v.ins;
        lo = -PSAT;
        hi = PSAT;
        if (!v.ins) begin
            ok = narrow_axis(psx, pex, bx0, bx1, lo, hi);
            ok = narrow_axis(psy, pey, by0, by1, lo, hi) && ok;
            if (ok && !(hi < 0 || lo > hi)) begin
                t = (lo < 0) ? hi : lo;
                v.hit = (t > 0) && (t < ONE);
            end
        end
        return v;
    endfunction

    function automatic coord_t pick_coord(bit wide);
        if (wide) return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    function automatic query_t random_query();
        query_t q;
        coord_t t;
        bit wide;
        wide = ($urandom_range(0, 9) == 0);
        q.sx = pick_coord(wide); q.sy = pick_coord(wide);
        q.ex = pick_coord(wide); q.ey = pick_coord(wide);
        q.x0 = pick_coord(wide); q.y0 = pick_coord(wide);
        q.x1 = pick_coord(wide); q.y1 = pick_coord(wide);
        if (!wide && $urandom_range(0, 9) != 0) begin
            if ($signed(q.x0) > $signed(q.x1)) begin t = q.x0; q.x0 = q.x1; q.x1 = t; end
            if ($signed(q.y0) > $signed(q.y1)) begin t = q.y0; q.y0 = q.y1; q.y1 = t; end
        end
        case ($urandom_range(0, 7))
            0: q.ex = q.sx;
            1: q.ey = q.sy;
            2: begin q.ex = q.sx; q.ey = q.sy; end
            3: q.sx = q.x0;
            default: ;
        endcase
        q.fixed = 0;
        q.hit = 0;
        q.ins = 0;
        return q;
    endfunction

    task automatic offer(query_t q, bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1;
        s_start_x   <= q.sx; s_start_y   <= q.sy;
        s_end_x     <= q.ex; s_end_y     <= q.ey;
        s_box_min_x <= q.x0; s_box_min_y <= q.y0;
        s_box_max_x <= q.x1; s_box_max_y <= q.y1;
        cur_fixed   <= q.fixed;
        cur_hit     <= q.hit;
        cur_ins     <= q.ins;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && s_valid && s_ready) begin
            if (cur_fixed) begin
                want.hit = cur_hit;
                want.ins = cur_ins;
            end else begin
                want = classify(s_start_x, s_start_y, s_end_x, s_end_y,
                                s_box_min_x, s_box_min_y, s_box_max_x, s_box_max_y);
            end
            verdicts.push_back(want);
            accepted <= accepted + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (verdicts.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result hit=%0b endpoint_inside=%0b",
                         $time, m_hit, m_endpoint_inside);
            end else begin
                want = verdicts.pop_front();
                if (m_hit !== want.hit) begin
                    errors = errors + 1;
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_hit);
                end
                if (m_endpoint_inside !== want.ins) begin
                    errors = errors + 1;
                    $display("%0t: endpoint_inside expected %0b actual %0b",
                             $time, want.ins, m_endpoint_inside);
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold, none near the end
    initial begin
        bit held;
        int len;
        held = 0;
        m_ready <= 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && accepted >= 400) begin
                held = 1;
                m_ready <= 0;
                repeat (HOLD_CYC) @(posedge aclk);
            end else if (total_items > 0 && accepted > total_items - 300) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                len = $urandom_range(1, 5);
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat (len) @(posedge aclk);
            end
        end
    end

    initial begin
        query_t q;
        rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 0, 0});
        rows.push_back('{32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'hFFF6_0000, 32'hFFF6_0000,
                         32'h000A_0000, 32'h000A_0000, 1, 1, 1});
        rows.push_back('{32'h0014_0000, 32'h0014_0000, 32'h0014_0000, 32'h0014_0000,
                         32'hFFF6_0000, 32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 1, 0, 0});
        rows.push_back('{32'hFFEC_0000, 32'h0, 32'h0014_0000, 32'h0, 32'hFFF6_0000,
                         32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 1, 1, 0});
        rows.push_back('{32'hFFEC_0000, 32'h0014_0000, 32'h0014_0000, 32'h0014_0000,
                         32'hFFF6_0000, 32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 1, 0, 0});
        rows.push_back('{32'hFFEC_0000, 32'h000A_0000, 32'h0014_0000, 32'h000A_0000,
                         32'hFFF6_0000, 32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 1, 0, 0});
        rows.push_back('{32'hFFEC_0000, 32'h0, 32'hFFF0_0000, 32'h0, 32'hFFF6_0000,
                         32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 1, 0, 0});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 0, 0, 0});
        rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0});
        rows.push_back('{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFE, 32'h0,
                         32'h7FFF_FFFF, 32'h2, 0, 0, 0});
        rows.push_back('{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                         32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0001, 0, 0, 0});
        rows.push_back('{32'hFFEC_0000, 32'h0, 32'h0014_0000, 32'h0, 32'h000A_0000,
                         32'hFFF6_0000, 32'hFFF6_0000, 32'h000A_0000, 0, 0, 0});
        rows.push_back('{32'hFFEC_0000, 32'hFFEC_0000, 32'h0014_0000, 32'h0014_0000,
                         32'hFFF6_0000, 32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 0, 0, 0});
        rows.push_back('{32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF,
                         32'h0, 32'h0000_0001, 0, 0, 0});
        rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0});
        rows.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1});
        total_items = rows.size() + N_RAND;

        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i]) offer(rows[i], 1);
        for (int i = 0; i < N_RAND; i++) begin
            if (i == 1000) begin
                s_valid <= 0;
                @(posedge aclk);
                while (verdicts.size() != 0) @(posedge aclk);
            end
            q = random_query();
            offer(q, i < N_RAND - 300);
        end
        s_valid <= 0;
        @(posedge aclk);
        while (verdicts.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/sai_pkg.sv
design/sai_div.sv
design/segment_aabb_intersect.sv
design/sai_checker.sv
tb/sv/testbench.sv
